FILE: src/phe_pkg.sv
`default_nettype none
package phe_pkg;

	localparam int TABLE_DEPTH_DEF = 256;

	localparam int PIX_W     = 8;
	localparam int COL_W     = 24;
	localparam int IDX_W     = 8;
	localparam int LANE_W    = 16;
	localparam int ERR_W     = 18;
	localparam int LEN_W     = 9;
	localparam int EXP_W     = 2;
	localparam int CH_W      = 2;
	localparam int NUM_W     = ERR_W + LEN_W;
	localparam int LANES     = 3;
	localparam int CFG_IDX_W = 3;
	localparam int CFG_W     = 18;

	localparam logic [ERR_W-1:0] MIN_ERROR_RST     = 18'd0;
	localparam logic [ERR_W-1:0] MAX_ERROR_RST     = 18'd195075;
	localparam logic [EXP_W-1:0] EXPONENT_RST      = 2'd1;
	localparam logic             USE_MASK_RST      = 1'b0;
	localparam logic [CH_W-1:0]  CHANNELS_USED_RST = 2'd3;
	localparam logic [LEN_W-1:0] BAR_LENGTH_RST    = 9'd256;

	localparam logic [EXP_W-1:0] EXP_SQUARE   = 2'd2;
	localparam logic             ACT_WRITE    = 1'b1;
	localparam logic [PIX_W-1:0] ALPHA_OPAQUE = 8'd255;

	typedef enum logic [CFG_IDX_W-1:0] {
		REG_MIN_ERROR,
		REG_MAX_ERROR,
		REG_EXPONENT,
		REG_USE_MASK,
		REG_CHANNELS_USED,
		REG_BAR_LENGTH
	} cfg_reg_t;

	typedef struct packed {
		logic             action;
		logic [PIX_W-1:0] first_red;
		logic [PIX_W-1:0] first_green;
		logic [PIX_W-1:0] first_blue;
		logic [PIX_W-1:0] second_red;
		logic [PIX_W-1:0] second_green;
		logic [PIX_W-1:0] second_blue;
		logic [PIX_W-1:0] mask_value;
		logic [IDX_W-1:0] entry_index;
		logic [COL_W-1:0] entry_colour;
	} req_t;

	typedef struct packed {
		logic [PIX_W-1:0] out_red;
		logic [PIX_W-1:0] out_green;
		logic [PIX_W-1:0] out_blue;
		logic [PIX_W-1:0] out_alpha;
		logic             bad_setting;
	} rsp_t;

	typedef struct packed {
		logic             wr;
		logic             masked;
		logic [IDX_W-1:0] entry_index;
		logic [COL_W-1:0] entry_colour;
	} ctrl_t;

endpackage
`default_nettype wire

FILE: src/phe_ram.sv
`default_nettype none
module phe_ram #(
	parameter int WIDTH = 24,
	parameter int DEPTH = 256
) (
	input  wire logic                     clk,
	input  wire logic                     we,
	input  wire logic [$clog2(DEPTH)-1:0] waddr,
	input  wire logic [WIDTH-1:0]         wdata,
	input  wire logic                     re,
	input  wire logic [$clog2(DEPTH)-1:0] raddr,
	output logic      [WIDTH-1:0]         rdata
);

	logic [WIDTH-1:0] mem_q [DEPTH];

	always_ff @(posedge clk) begin
		if (we) begin
			mem_q[waddr] <= wdata;
		end
		if (re) begin
			rdata <= mem_q[raddr];
		end
	end

endmodule
`default_nettype wire

FILE: src/phe_lane.sv
`default_nettype none
module phe_lane (
	input  wire logic                        clk,
	input  wire logic                        en,
	input  wire logic                        active,
	input  wire logic                        square,
	input  wire logic [phe_pkg::PIX_W-1:0]   a,
	input  wire logic [phe_pkg::PIX_W-1:0]   b,
	output logic      [phe_pkg::LANE_W-1:0]  err_s1
);
	import phe_pkg::*;

	logic [PIX_W-1:0]  diff;
	logic [LANE_W-1:0] sq;

	assign diff = (a > b) ? a - b : b - a;
	assign sq   = LANE_W'(diff) * LANE_W'(diff);

	always_ff @(posedge clk) begin
		if (en) begin
			if (!active) begin
				err_s1 <= '0;
			end else if (square) begin
				err_s1 <= sq;
			end else begin
				err_s1 <= LANE_W'(diff);
			end
		end
	end

endmodule
`default_nettype wire

FILE: src/phe_merge.sv
`default_nettype none
module phe_merge (
	input  wire logic                                   clk,
	input  wire logic                                   en_sum,
	input  wire logic                                   en_mul,
	input  wire logic [phe_pkg::LANES-1:0][phe_pkg::LANE_W-1:0] err_s1,
	input  wire logic [phe_pkg::ERR_W-1:0]              min_error,
	input  wire logic [phe_pkg::ERR_W-1:0]              max_error,
	input  wire logic [phe_pkg::LEN_W-1:0]              len,
	output logic      [phe_pkg::NUM_W-1:0]              num_s3
);
	import phe_pkg::*;

	logic [ERR_W-1:0] sum;
	logic [ERR_W-1:0] clamped;
	logic [ERR_W-1:0] span_s2;

	always_comb begin
		sum = '0;
		for (int i = 0; i < LANES; i++) begin
			sum = sum + ERR_W'(err_s1[i]);
		end
		clamped = sum;
		if (clamped < min_error) begin
			clamped = min_error;
		end
		if (clamped > max_error) begin
			clamped = max_error;
		end
	end

	always_ff @(posedge clk) begin
		if (en_sum) begin
			span_s2 <= clamped - min_error;
		end
		if (en_mul) begin
			num_s3 <= NUM_W'(len) * NUM_W'(span_s2);
		end
	end

endmodule
`default_nettype wire

FILE: src/phe_div.sv
`default_nettype none
module phe_div #(
	parameter int SHIFT = 0
) (
	input  wire logic                       clk,
	input  wire logic                       en,
	input  wire logic [phe_pkg::ERR_W-1:0]  divisor,
	input  wire logic [phe_pkg::NUM_W-1:0]  rem_i,
	input  wire logic [phe_pkg::LEN_W-1:0]  quo_i,
	output logic      [phe_pkg::NUM_W-1:0]  rem_o,
	output logic      [phe_pkg::LEN_W-1:0]  quo_o
);
	import phe_pkg::*;

	logic [NUM_W-1:0] dsh;
	logic             ge;

	assign dsh = NUM_W'(divisor) << SHIFT;
	assign ge  = rem_i >= dsh;

	always_ff @(posedge clk) begin
		if (en) begin
			rem_o <= ge ? rem_i - dsh : rem_i;
			quo_o <= {quo_i[LEN_W-2:0], ge};
		end
	end

endmodule
`default_nettype wire

FILE: src/pixel_error_heatmap.sv
`default_nettype none
// Error heat-map colouring of pixel pairs.
// req: one word per item. action 0 compares a pixel pair and yields one rsp
// word; action 1 writes one colour-bar entry and yields nothing. Table
// writes stay in order with compares, so a compare sees every earlier write.
// rsp: chosen colour with alpha 255, or all zero with bad_setting set when
// min_error is not below max_error.
// Each req word passes three lanes that form the channel errors, then
// sum/clamp, the length product, nine restoring divide steps of one quotient
// bit each, and the registered table read. One word per cycle is taken in
// steady state while rsp is not stalled.
// When rsp is stalled, words advance into empty stages behind it; req_ready
// drops only once every stage holds a word.
// cfg: write-only, taken whenever cfg_we is high; change it only while idle.
// Reset restores the register defaults and empties the pipeline; the colour
// table is not cleared, and entries must be written before being chosen.
module pixel_error_heatmap #(
	parameter int TABLE_DEPTH = phe_pkg::TABLE_DEPTH_DEF
) (
	input  wire logic                              clk,
	input  wire logic                              arst_n,
	input  wire logic                              req_valid,
	output logic                                   req_ready,
	input  wire phe_pkg::req_t                     req,
	output logic                                   rsp_valid,
	input  wire logic                              rsp_ready,
	output phe_pkg::rsp_t                          rsp,
	input  wire logic                              cfg_we,
	input  wire logic [phe_pkg::CFG_IDX_W-1:0]     cfg_index,
	input  wire logic [phe_pkg::CFG_W-1:0]         cfg_data
);
	import phe_pkg::*;

	localparam int AW   = $clog2(TABLE_DEPTH);
	localparam int NSTG = 3 + LEN_W;

	logic [ERR_W-1:0] min_error_q;
	logic [ERR_W-1:0] max_error_q;
	logic [EXP_W-1:0] exponent_q;
	logic             use_mask_q;
	logic [CH_W-1:0]  channels_used_q;
	logic [LEN_W-1:0] bar_length_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			min_error_q     <= MIN_ERROR_RST;
			max_error_q     <= MAX_ERROR_RST;
			exponent_q      <= EXPONENT_RST;
			use_mask_q      <= USE_MASK_RST;
			channels_used_q <= CHANNELS_USED_RST;
			bar_length_q    <= BAR_LENGTH_RST;
		end else if (cfg_we) begin
			case (cfg_reg_t'(cfg_index))
				REG_MIN_ERROR:     min_error_q     <= cfg_data[ERR_W-1:0];
				REG_MAX_ERROR:     max_error_q     <= cfg_data[ERR_W-1:0];
				REG_EXPONENT:      exponent_q      <= cfg_data[EXP_W-1:0];
				REG_USE_MASK:      use_mask_q      <= cfg_data[0];
				REG_CHANNELS_USED: channels_used_q <= cfg_data[CH_W-1:0];
				REG_BAR_LENGTH:    bar_length_q    <= cfg_data[LEN_W-1:0];
				default: ;
			endcase
		end
	end

	logic [LEN_W-1:0] len;
	logic [LEN_W-1:0] last_idx;
	logic [ERR_W-1:0] span;
	logic             bad;

	always_comb begin
		len = bar_length_q;
		if (len == '0) begin
			len = LEN_W'(1);
		end
		if (32'(bar_length_q) > TABLE_DEPTH) begin
			len = LEN_W'(TABLE_DEPTH);
		end
	end

	assign last_idx = len - LEN_W'(1);
	assign span     = max_error_q - min_error_q;
	assign bad      = min_error_q >= max_error_q;

	// stage enables, collapsing bubbles behind a stalled output
	logic [NSTG:0]   adv;
	logic [NSTG-1:0] vld_q;
	ctrl_t           ctrl_q [NSTG];
	ctrl_t           ctrl_in;

	assign adv[NSTG] = !rsp_valid || rsp_ready;
	for (genvar i = 0; i < NSTG; i++) begin : g_adv
		assign adv[i] = !vld_q[i] || adv[i+1];
	end
	assign req_ready = adv[0];

	assign ctrl_in.wr           = req.action == ACT_WRITE;
	assign ctrl_in.masked       = use_mask_q && (req.mask_value == '0);
	assign ctrl_in.entry_index  = req.entry_index;
	assign ctrl_in.entry_colour = req.entry_colour;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_q <= '0;
		end else begin
			if (adv[0]) begin
				vld_q[0] <= req_valid;
			end
			for (int i = 1; i < NSTG; i++) begin
				if (adv[i]) begin
					vld_q[i] <= vld_q[i-1];
				end
			end
		end
	end

	always_ff @(posedge clk) begin
		if (adv[0]) begin
			ctrl_q[0] <= ctrl_in;
		end
		for (int i = 1; i < NSTG; i++) begin
			if (adv[i]) begin
				ctrl_q[i] <= ctrl_q[i-1];
			end
		end
	end

	logic [LANES-1:0][PIX_W-1:0]  pa;
	logic [LANES-1:0][PIX_W-1:0]  pb;
	logic [LANES-1:0][LANE_W-1:0] err_s1;

	assign pa = {req.first_blue, req.first_green, req.first_red};
	assign pb = {req.second_blue, req.second_green, req.second_red};

	for (genvar k = 0; k < LANES; k++) begin : g_lane
		phe_lane u_lane (
			.clk    (clk),
			.en     (adv[0]),
			.active (channels_used_q > CH_W'(k)),
			.square (exponent_q == EXP_SQUARE),
			.a      (pa[k]),
			.b      (pb[k]),
			.err_s1 (err_s1[k])
		);
	end

	logic [NUM_W-1:0] rem [LEN_W+1];
	logic [LEN_W-1:0] quo [LEN_W+1];

	phe_merge u_merge (
		.clk       (clk),
		.en_sum    (adv[1]),
		.en_mul    (adv[2]),
		.err_s1    (err_s1),
		.min_error (min_error_q),
		.max_error (max_error_q),
		.len       (len),
		.num_s3    (rem[0])
	);

	assign quo[0] = '0;

	for (genvar k = 0; k < LEN_W; k++) begin : g_div
		phe_div #(
			.SHIFT (LEN_W - 1 - k)
		) u_div (
			.clk     (clk),
			.en      (adv[3+k]),
			.divisor (span),
			.rem_i   (rem[k]),
			.quo_i   (quo[k]),
			.rem_o   (rem[k+1]),
			.quo_o   (quo[k+1])
		);
	end

	ctrl_t            tail;
	logic [LEN_W-1:0] entry;
	logic             go;
	logic             wr_ok;
	logic [COL_W-1:0] rdata;
	logic             bad_q;

	assign tail  = ctrl_q[NSTG-1];
	assign go    = vld_q[NSTG-1] && adv[NSTG];
	assign wr_ok = 32'(tail.entry_index) < TABLE_DEPTH;

	always_comb begin
		entry = (quo[LEN_W] > last_idx) ? last_idx : quo[LEN_W];
		if (tail.masked) begin
			entry = '0;
		end
	end

	phe_ram #(
		.WIDTH (COL_W),
		.DEPTH (TABLE_DEPTH)
	) u_table (
		.clk   (clk),
		.we    (go && tail.wr && wr_ok),
		.waddr (AW'(tail.entry_index)),
		.wdata (tail.entry_colour),
		.re    (go && !tail.wr),
		.raddr (AW'(entry)),
		.rdata (rdata)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			rsp_valid <= 1'b0;
		end else if (adv[NSTG]) begin
			rsp_valid <= vld_q[NSTG-1] && !tail.wr;
		end
	end

	always_ff @(posedge clk) begin
		if (go && !tail.wr) begin
			bad_q <= bad;
		end
	end

	assign rsp.out_red     = bad_q ? '0 : rdata[7:0];
	assign rsp.out_green   = bad_q ? '0 : rdata[15:8];
	assign rsp.out_blue    = bad_q ? '0 : rdata[23:16];
	assign rsp.out_alpha   = bad_q ? '0 : ALPHA_OPAQUE;
	assign rsp.bad_setting = bad_q;

endmodule
`default_nettype wire

FILE: bench/tb_pixel_error_heatmap.sv
`timescale 1ns / 100ps
module tb_pixel_error_heatmap;
	import phe_pkg::*;

	localparam logic ACT_PIXEL = ~ACT_WRITE;
	localparam int STUCK_LIMIT = 3000;
	localparam int DRAIN_CYCLES = 20;

	logic clk;
	logic arst_n = 1'b0;
	logic req_valid = 1'b0;
	logic req_ready;
	req_t req = '0;
	logic rsp_valid;
	logic rsp_ready = 1'b0;
	rsp_t rsp;
	logic cfg_we = 1'b0;
	logic [CFG_IDX_W-1:0] cfg_index = '0;
	logic [CFG_W-1:0] cfg_data = '0;

	// current register settings, as the block should hold them
	logic [ERR_W-1:0] lim_lo = MIN_ERROR_RST;
	logic [ERR_W-1:0] lim_hi = MAX_ERROR_RST;
	logic [EXP_W-1:0] pow_sel = EXPONENT_RST;
	logic mask_en = USE_MASK_RST;
	logic [CH_W-1:0] chan_cnt = CHANNELS_USED_RST;
	logic [LEN_W-1:0] bar_len = BAR_LENGTH_RST;

	logic [COL_W-1:0] bar_colour [TABLE_DEPTH_DEF];
	bit bar_loaded [TABLE_DEPTH_DEF];

	req_t pixel_queue [$];
	rsp_t heat_expect [$];
	rsp_t want_word;

	int burst_left = 1;
	int gap_left = 0;
	logic [1:0] ready_mode = 2'd0;
	logic [5:0] ready_tick = '0;
	int stuck = 0;
	int mismatches = 0;
	int compares = 0;
	int table_writes = 0;
	int words_checked = 0;
	int bad_seen = 0;
	int settings = 0;

	pixel_error_heatmap uut (
		.clk(clk),
		.arst_n(arst_n),
		.req_valid(req_valid),
		.req_ready(req_ready),
		.req(req),
		.rsp_valid(rsp_valid),
		.rsp_ready(rsp_ready),
		.rsp(rsp),
		.cfg_we(cfg_we),
		.cfg_index(cfg_index),
		.cfg_data(cfg_data)
	);

	initial begin
		clk = 1'b0;
		forever #1 clk = ~clk;
	end

	// colour-bar index the block should pick for a pixel pair
	function automatic int unsigned heat_entry(req_t p);
		logic [PIX_W-1:0] fa [LANES];
		logic [PIX_W-1:0] sa [LANES];
		int unsigned sum;
		int unsigned d;
		longint unsigned len;
		longint unsigned span;
		longint unsigned q;
		if (mask_en && p.mask_value == 0)
			return 0;
		fa[0] = p.first_red;
		fa[1] = p.first_green;
		fa[2] = p.first_blue;
		sa[0] = p.second_red;
		sa[1] = p.second_green;
		sa[2] = p.second_blue;
		sum = 0;
		for (int c = 0; c < LANES; c++) begin
			if (c < chan_cnt) begin
				d = (fa[c] > sa[c]) ? fa[c] - sa[c] : sa[c] - fa[c];
				sum += (pow_sel == EXP_SQUARE) ? d * d : d;
			end
		end
		if (sum < lim_lo)
			sum = lim_lo;
		if (sum > lim_hi)
			sum = lim_hi;
		len = bar_len;
		if (len < 1)
			len = 1;
		if (len > TABLE_DEPTH_DEF)
			len = TABLE_DEPTH_DEF;
		span = lim_hi - lim_lo;
		q = (len * (sum - lim_lo)) / span;
		if (q > len - 1)
			q = len - 1;
		return int'(q);
	endfunction

	function automatic rsp_t heat_pixel(req_t p);
		rsp_t r;
		logic [COL_W-1:0] c;
		r = '0;
		if (lim_lo >= lim_hi) begin
			r.bad_setting = 1'b1;
			return r;
		end
		c = bar_colour[heat_entry(p)];
		r.out_red = c[7:0];
		r.out_green = c[15:8];
		r.out_blue = c[23:16];
		r.out_alpha = 8'd255;
		return r;
	endfunction

	function automatic void check_out_field(string name, logic [7:0] want, logic [7:0] got);
		if (got !== want) begin
			$display("%0t ns: %s expected %0d, got %0d", $time, name, want, got);
			mismatches++;
		end
	endfunction

	// driver: bursts of words with random gaps
	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			req_valid <= 1'b0;
			req <= '0;
		end else if (!req_valid || req_ready) begin
			if (gap_left != 0) begin
				gap_left--;
				req_valid <= 1'b0;
			end else if (pixel_queue.size() != 0) begin
				req <= pixel_queue.pop_front();
				req_valid <= 1'b1;
				if (burst_left <= 1) begin
					burst_left = $urandom_range(1, 40);
					gap_left = ($urandom_range(0, 2) == 0) ? 0 : $urandom_range(1, 6);
				end else begin
					burst_left--;
				end
			end else begin
				req_valid <= 1'b0;
			end
		end
	end

	// monitor: checks rsp words, predicts from accepted req words, paces rsp_ready
	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			rsp_ready <= 1'b0;
			ready_mode <= 2'd0;
			ready_tick <= '0;
		end else begin
			if (rsp_valid && rsp_ready) begin
				if (heat_expect.size() == 0) begin
					$display("%0t ns: rsp word with none expected, got %p", $time, rsp);
					mismatches++;
				end else begin
					want_word = heat_expect.pop_front();
					check_out_field("out_red", want_word.out_red, rsp.out_red);
					check_out_field("out_green", want_word.out_green, rsp.out_green);
					check_out_field("out_blue", want_word.out_blue, rsp.out_blue);
					check_out_field("out_alpha", want_word.out_alpha, rsp.out_alpha);
					check_out_field("bad_setting", want_word.bad_setting, rsp.bad_setting);
					words_checked++;
					if (want_word.bad_setting)
						bad_seen++;
				end
			end
			if (req_valid && req_ready) begin
				if (req.action == ACT_WRITE) begin
					bar_colour[req.entry_index] = req.entry_colour;
					table_writes++;
				end else begin
					heat_expect.push_back(heat_pixel(req));
					compares++;
				end
			end
			ready_tick <= ready_tick + 1'b1;
			if (ready_tick == 0)
				ready_mode <= 2'($urandom_range(0, 3));
			case (ready_mode)
				2'd0: rsp_ready <= 1'b1;
				2'd1: rsp_ready <= ($urandom_range(0, 9) < 7);
				2'd2: rsp_ready <= ($urandom_range(0, 3) == 0);
				default: rsp_ready <= ready_tick[3];
			endcase
		end
	end

	always @(posedge clk) begin
		if (arst_n) begin
			if ((req_valid && req_ready) || (rsp_valid && rsp_ready))
				stuck = 0;
			else
				stuck++;
			if (stuck >= STUCK_LIMIT) begin
				$display("%0t ns: no handshake for %0d cycles", $time, stuck);
				$display("Mismatches found");
				$finish;
			end
		end
	end

	function automatic req_t rand_word();
		logic [95:0] bits;
		req_t w;
		bits = {$urandom(), $urandom(), $urandom()};
		w = bits[$bits(req_t)-1:0];
		return w;
	endfunction

	function automatic req_t mk_pixel(logic [7:0] fr, logic [7:0] fg, logic [7:0] fb,
			logic [7:0] sr, logic [7:0] sg, logic [7:0] sb, logic [7:0] mv);
		req_t p;
		p = '0;
		p.action = ACT_PIXEL;
		p.first_red = fr;
		p.first_green = fg;
		p.first_blue = fb;
		p.second_red = sr;
		p.second_green = sg;
		p.second_blue = sb;
		p.mask_value = mv;
		return p;
	endfunction

	function automatic req_t rand_pixel();
		req_t p;
		p = rand_word();
		p.action = ACT_PIXEL;
		case ($urandom_range(0, 3))
			0: ;
			1: begin
				p.second_red = p.first_red ^ 8'($urandom_range(0, 7));
				p.second_green = p.first_green ^ 8'($urandom_range(0, 7));
				p.second_blue = p.first_blue ^ 8'($urandom_range(0, 7));
			end
			2: begin
				p.first_red = {8{p.first_red[0]}};
				p.first_green = {8{p.first_green[0]}};
				p.first_blue = {8{p.first_blue[0]}};
				p.second_red = {8{p.second_red[0]}};
				p.second_green = {8{p.second_green[0]}};
				p.second_blue = {8{p.second_blue[0]}};
			end
			default: begin
				p.second_red = p.first_red;
				p.second_green = p.first_green;
				p.second_blue = p.first_blue;
			end
		endcase
		if ($urandom_range(0, 4) == 0)
			p.mask_value = '0;
		return p;
	endfunction

	task automatic queue_entry(logic [7:0] idx, logic [23:0] colour);
		req_t w;
		w = rand_word();
		w.action = ACT_WRITE;
		w.entry_index = idx;
		w.entry_colour = colour;
		bar_loaded[idx] = 1'b1;
		pixel_queue.push_back(w);
	endtask

	// loads the chosen entry first if it was never written
	task automatic queue_pixel(req_t p);
		int unsigned e;
		if (lim_lo < lim_hi) begin
			e = heat_entry(p);
			if (!bar_loaded[e])
				queue_entry(e[7:0], 24'($urandom()));
		end
		pixel_queue.push_back(p);
	endtask

	task automatic queue_random(int n);
		for (int i = 0; i < n; i++) begin
			if ($urandom_range(0, 6) == 0)
				queue_entry(8'($urandom()), 24'($urandom()));
			else
				queue_pixel(rand_pixel());
		end
	endtask

	task automatic wait_idle();
		@(negedge clk);
		while (pixel_queue.size() != 0 || req_valid || heat_expect.size() != 0)
			@(negedge clk);
	endtask

	task automatic write_reg(cfg_reg_t rg, logic [CFG_W-1:0] d);
		@(posedge clk);
		cfg_we <= 1'b1;
		cfg_index <= rg;
		cfg_data <= d;
	endtask

	task automatic set_heatmap(int unsigned lo, int unsigned hi, int unsigned pw,
			int unsigned mk, int unsigned ch, int unsigned len);
		wait_idle();
		// table writes give no word, so let the pipeline empty
		repeat (DRAIN_CYCLES) @(posedge clk);
		write_reg(REG_MIN_ERROR, lo[17:0]);
		write_reg(REG_MAX_ERROR, hi[17:0]);
		write_reg(REG_EXPONENT, pw[17:0]);
		write_reg(REG_USE_MASK, mk[17:0]);
		write_reg(REG_CHANNELS_USED, ch[17:0]);
		write_reg(REG_BAR_LENGTH, len[17:0]);
		@(posedge clk);
		cfg_we <= 1'b0;
		lim_lo = lo[ERR_W-1:0];
		lim_hi = hi[ERR_W-1:0];
		pow_sel = pw[EXP_W-1:0];
		mask_en = mk[0];
		chan_cnt = ch[CH_W-1:0];
		bar_len = len[LEN_W-1:0];
		settings++;
		@(negedge clk);
	endtask

	initial begin
		repeat (11) @(posedge clk);
		@(negedge clk);
		arst_n = 1'b1;

		set_heatmap(0, 765, 1, 1, 3, 256);
		queue_entry(8'd0, 24'hFFFFFF);
		queue_entry(8'd255, 24'h000000);
		queue_entry(8'd128, 24'h5AC3A5);
		queue_pixel(mk_pixel(0, 0, 0, 0, 0, 0, 1));
		queue_pixel(mk_pixel(0, 0, 0, 255, 255, 255, 255));
		queue_pixel(mk_pixel(255, 255, 255, 0, 0, 0, 1));
		queue_pixel(mk_pixel(255, 255, 255, 0, 0, 0, 0));
		queue_pixel(mk_pixel(200, 10, 0, 100, 10, 0, 128));
		queue_pixel(mk_pixel(1, 0, 0, 0, 0, 0, 2));
		queue_pixel(mk_pixel(255, 255, 254, 0, 0, 0, 3));
		queue_random(130);

		set_heatmap(MIN_ERROR_RST, MAX_ERROR_RST, EXPONENT_RST, USE_MASK_RST,
			CHANNELS_USED_RST, BAR_LENGTH_RST);
		queue_random(100);

		set_heatmap(0, 195075, 2, 0, 3, 256);
		queue_pixel(mk_pixel(0, 0, 0, 255, 255, 255, 1));
		queue_pixel(mk_pixel(0, 0, 0, 255, 0, 0, 1));
		queue_random(130);

		set_heatmap(100, 2000, 2, 1, 2, 37);
		queue_random(120);

		// min above max: bad range
		set_heatmap(195075, 0, 1, 1, 3, 256);
		queue_pixel(mk_pixel(0, 0, 0, 255, 255, 255, 0));
		queue_random(50);

		set_heatmap(500, 500, 2, 0, 3, 100);
		queue_random(40);

		set_heatmap(0, 1, 0, 0, 1, 1);
		queue_random(80);

		// no channels summed, odd exponent, zero bar length
		set_heatmap(10, 300, 3, 1, 0, 0);
		queue_pixel(mk_pixel(0, 0, 0, 255, 255, 255, 9));
		queue_random(80);

		set_heatmap(195074, 195075, 2, 0, 3, 511);
		queue_random(120);

		set_heatmap(50, 700, 1, 0, 3, 200);
		queue_random(150);

		set_heatmap(0, 3, 1, 1, 1, 256);
		queue_random(150);

		wait_idle();
		repeat (DRAIN_CYCLES) @(posedge clk);
		if (heat_expect.size() != 0) begin
			$display("%0t ns: %0d expected words never arrived", $time, heat_expect.size());
			mismatches += heat_expect.size();
		end
		$display("Checked %0d result words from %0d pixel compares, with %0d table writes.",
			words_checked, compares, table_writes);
		$display("Ran %0d register settings; %0d words reported a bad range.",
			settings, bad_seen);
		if (mismatches == 0)
			$display("No mismatches found");
		else
			$display("Mismatches found");
		$finish;
	end

endmodule
